// ===== rtl/core/qir_pkg.sv =====
// Shared constants, types and state codes for the quadratic interpolation resampler.
package qir_pkg;

   localparam int LEN_BITS   = 20;
   localparam int SRC_W      = LEN_BITS;
   localparam int DST_W      = LEN_BITS + 3;
   localparam int SAMPLE_W   = 8;
   localparam int PCM_W      = 16;
   localparam int MAX_RATIO  = 8;
   localparam int EMIT_W     = $clog2(MAX_RATIO + 1);

   localparam int DIV_W      = SRC_W + 1 + DST_W;
   localparam int STEP_W     = $clog2(DIV_W + 1);
   localparam int POS_STEPS  = SRC_W;
   localparam int FRAC_BITS  = 16;
   localparam int CEIL_STEPS = DIV_W;

   localparam int MUL_A_W    = 2 * FRAC_BITS + 1;
   localparam int MUL_B_W    = DST_W + 1;
   localparam int MUL_P_W    = MUL_A_W + MUL_B_W;

   localparam int ACC_W       = 46;
   localparam int S1_SHIFT    = 2 * FRAC_BITS + 1;
   localparam int TRUNC_SHIFT = 25;

   localparam logic [ACC_W-1:0] ROUND_BIAS =
      {{(ACC_W - TRUNC_SHIFT){1'b0}}, {TRUNC_SHIFT{1'b1}}};
   localparam logic signed [ACC_W-1:0] PCM_MAX = 32767;
   localparam logic signed [ACC_W-1:0] PCM_MIN = -32768;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = DST_W;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_LEN = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_LEN = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_POS_MUL,
      ST_POS_DIV,
      ST_FRAC_DIV,
      ST_MUL_G,
      ST_MUL_A,
      ST_MUL_B,
      ST_EMIT,
      ST_CEIL_MUL,
      ST_CEIL_DIV,
      ST_GROUP_END
   } state_type;

   typedef struct packed {
      logic              start;
      logic [STEP_W-1:0] steps;
      logic [DST_W-1:0]  divisor;
      logic [DST_W-1:0]  init_rem;
      logic [DIV_W-1:0]  bits;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic [DIV_W-1:0] quot;
      logic [DST_W-1:0] rem;
   } div_rsp_type;

   typedef struct packed {
      logic               en;
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } mul_req_type;

endpackage

// ===== rtl/core/quadratic_interp_resampler_unit.sv =====
// Top level of the three-point quadratic interpolation resampler.
// One 8-bit sample is taken per transfer while the block is idle; it then
// produces the interpolated outputs that fall between the previous samples
// and this one (up to 8 per group, up to 16 when it ends a sound) and
// returns to idle. Each output takes a multiply, then a position divide of
// 20 steps and a fraction divide of 16 steps on the one shared radix-2
// divider, then three more passes through the shared multiplier. Closing a
// group takes a final position test, and a group that overflows its output
// budget adds a 44-step divide to skip ahead. The output register lets one
// result wait for transfer while the next is computed.
module quadratic_interp_resampler_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [qir_pkg::SAMPLE_W-1:0]        req_raw_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [qir_pkg::PCM_W-1:0]    rsp_pcm_out,
   output logic                                rsp_last_of_sound,
   input  logic                                csr_we,
   input  logic [qir_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [qir_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import qir_pkg::*;

   state_type state_ff, state_in;

   logic [SRC_W-1:0]    src_len_ff, src_len_in;
   logic [DST_W-1:0]    dst_len_ff, dst_len_in;
   logic [SAMPLE_W-1:0] older_ff, older_in;
   logic [SAMPLE_W-1:0] middle_ff, middle_in;
   logic [SRC_W-1:0]    samples_ff, samples_in;
   logic [DST_W-1:0]    outputs_ff, outputs_in;

   logic [SAMPLE_W-1:0] cur_ff, cur_in;
   logic [SRC_W-1:0]    idx_ff, idx_in;
   logic                last_ff, last_in;
   logic                second_ff, second_in;
   logic [SRC_W-1:0]    k_ff, k_in;
   logic signed [SAMPLE_W-1:0] s0_ff, s0_in, s1_ff, s1_in, s2_ff, s2_in;
   logic [EMIT_W-1:0]   emitted_ff, emitted_in;
   logic [FRAC_BITS-1:0] f_ff, f_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [PCM_W-1:0] rsp_pcm_ff, rsp_pcm_in;
   logic                    rsp_last_ff, rsp_last_in;

   div_req_type div_req;
   div_rsp_type div_rsp;
   mul_req_type mul_req;
   logic signed [MUL_P_W-1:0] prod;

   logic [SAMPLE_W-1:0]     cur;
   logic                    last_now;
   logic signed [9:0]       coef_a;
   logic signed [8:0]       coef_b;
   logic [SRC_W:0]          k_plus;
   logic [DIV_W-1:0]        ceil_num;
   logic signed [ACC_W-1:0] rounded;
   logic signed [ACC_W-1:0] scaled;
   logic signed [PCM_W-1:0] pcm_sat;
   logic                    out_free;

   qir_div_unit u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   qir_mul_unit u_mul (
      .clock (clock),
      .req   (mul_req),
      .prod  (prod)
   );

   always_comb begin
      cur      = req_raw_sample ^ 8'h80;
      last_now = ({1'b0, samples_ff} + 1'b1) >= {1'b0, src_len_ff};
      coef_a   = {{2{s0_ff[7]}}, s0_ff} - {s1_ff[7], s1_ff, 1'b0} + {{2{s2_ff[7]}}, s2_ff};
      coef_b   = {s2_ff[7], s2_ff} - {s0_ff[7], s0_ff};
      k_plus   = {1'b0, k_ff} + 1'b1;
      ceil_num = prod[DIV_W-1:0] + {{(DIV_W - SRC_W){1'b0}}, src_len_ff} - 1'b1;
      rounded  = acc_ff + (acc_ff[ACC_W-1] ? ROUND_BIAS : '0);
      scaled   = rounded >>> TRUNC_SHIFT;
      if (scaled > PCM_MAX) begin
         pcm_sat = PCM_MAX[PCM_W-1:0];
      end else if (scaled < PCM_MIN) begin
         pcm_sat = PCM_MIN[PCM_W-1:0];
      end else begin
         pcm_sat = scaled[PCM_W-1:0];
      end
      out_free = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      state_in   = state_ff;
      src_len_in = src_len_ff;
      dst_len_in = dst_len_ff;
      older_in   = older_ff;
      middle_in  = middle_ff;
      samples_in = samples_ff;
      outputs_in = outputs_ff;
      cur_in     = cur_ff;
      idx_in     = idx_ff;
      last_in    = last_ff;
      second_in  = second_ff;
      k_in       = k_ff;
      s0_in      = s0_ff;
      s1_in      = s1_ff;
      s2_in      = s2_ff;
      emitted_in = emitted_ff;
      f_in       = f_ff;
      acc_in     = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_pcm_in   = rsp_pcm_ff;
      rsp_last_in  = rsp_last_ff;
      req_ready    = 1'b0;
      div_req      = '0;
      mul_req      = '0;

      if (csr_we) begin
         case (csr_index)
            CSR_SRC_LEN: src_len_in = csr_wdata[SRC_W-1:0];
            CSR_DST_LEN: dst_len_in = csr_wdata[DST_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cur_in     = cur;
               idx_in     = samples_ff;
               last_in    = last_now;
               emitted_in = '0;
               if (samples_ff != '0) begin
                  second_in = 1'b0;
                  k_in      = samples_ff - 1'b1;
                  s0_in     = older_ff;
                  s1_in     = middle_ff;
                  s2_in     = cur;
                  state_in  = ST_CHECK;
               end else begin
                  second_in = 1'b1;
                  k_in      = samples_ff;
                  s0_in     = middle_ff;
                  s1_in     = cur;
                  s2_in     = '0;
                  state_in  = last_now ? ST_CHECK : ST_GROUP_END;
               end
            end
         end
         ST_CHECK: begin
            if (outputs_ff >= dst_len_ff) begin
               state_in = ST_GROUP_END;
            end else begin
               mul_req.en = 1'b1;
               mul_req.a  = {{(MUL_A_W - DST_W){1'b0}}, outputs_ff};
               mul_req.b  = {{(MUL_B_W - SRC_W){1'b0}}, src_len_ff};
               state_in   = ST_POS_MUL;
            end
         end
         ST_POS_MUL: begin
            div_req.start    = 1'b1;
            div_req.steps    = STEP_W'(POS_STEPS);
            div_req.divisor  = dst_len_ff;
            div_req.init_rem = prod[DST_W+SRC_W-1:SRC_W];
            div_req.bits     = {prod[SRC_W-1:0], {(DIV_W - SRC_W){1'b0}}};
            state_in         = ST_POS_DIV;
         end
         ST_POS_DIV: begin
            if (!div_rsp.busy) begin
               if (div_rsp.quot[SRC_W-1:0] > k_ff) begin
                  state_in = ST_GROUP_END;
               end else if (emitted_ff == EMIT_W'(MAX_RATIO)) begin
                  if (src_len_ff == '0) begin
                     outputs_in = dst_len_ff;
                     state_in   = ST_GROUP_END;
                  end else begin
                     mul_req.en = 1'b1;
                     mul_req.a  = {{(MUL_A_W - SRC_W - 1){1'b0}}, k_plus};
                     mul_req.b  = {1'b0, dst_len_ff};
                     state_in   = ST_CEIL_MUL;
                  end
               end else begin
                  div_req.start    = 1'b1;
                  div_req.steps    = STEP_W'(FRAC_BITS);
                  div_req.divisor  = dst_len_ff;
                  div_req.init_rem = div_rsp.rem;
                  div_req.bits     = '0;
                  state_in         = ST_FRAC_DIV;
               end
            end
         end
         ST_FRAC_DIV: begin
            if (!div_rsp.busy) begin
               f_in       = div_rsp.quot[FRAC_BITS-1:0];
               mul_req.en = 1'b1;
               mul_req.a  = {{(MUL_A_W - FRAC_BITS){1'b0}}, div_rsp.quot[FRAC_BITS-1:0]};
               mul_req.b  = {{(MUL_B_W - FRAC_BITS){1'b0}}, div_rsp.quot[FRAC_BITS-1:0]};
               state_in   = ST_MUL_G;
            end
         end
         ST_MUL_G: begin
            mul_req.en = 1'b1;
            mul_req.a  = {1'b0, prod[2*FRAC_BITS-1:0]};
            mul_req.b  = {{(MUL_B_W - 10){coef_a[9]}}, coef_a};
            state_in   = ST_MUL_A;
         end
         ST_MUL_A: begin
            acc_in     = prod[ACC_W-1:0];
            mul_req.en = 1'b1;
            mul_req.a  = {{(MUL_A_W - FRAC_BITS){1'b0}}, f_ff};
            mul_req.b  = {{(MUL_B_W - 9){coef_b[8]}}, coef_b};
            state_in   = ST_MUL_B;
         end
         ST_MUL_B: begin
            acc_in = acc_ff
                   + {prod[ACC_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}}
                   + {{(ACC_W - SAMPLE_W - S1_SHIFT){s1_ff[7]}}, s1_ff, {S1_SHIFT{1'b0}}};
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_pcm_in   = pcm_sat;
               rsp_last_in  = ({1'b0, outputs_ff} + 1'b1) == {1'b0, dst_len_ff};
               outputs_in   = outputs_ff + 1'b1;
               emitted_in   = emitted_ff + 1'b1;
               state_in     = ST_CHECK;
            end
         end
         ST_CEIL_MUL: begin
            div_req.start    = 1'b1;
            div_req.steps    = STEP_W'(CEIL_STEPS);
            div_req.divisor  = {{(DST_W - SRC_W){1'b0}}, src_len_ff};
            div_req.init_rem = '0;
            div_req.bits     = ceil_num;
            state_in         = ST_CEIL_DIV;
         end
         ST_CEIL_DIV: begin
            if (!div_rsp.busy) begin
               if (div_rsp.quot > {{(DIV_W - DST_W){1'b0}}, dst_len_ff}) begin
                  outputs_in = dst_len_ff;
               end else begin
                  outputs_in = div_rsp.quot[DST_W-1:0];
               end
               state_in = ST_GROUP_END;
            end
         end
         ST_GROUP_END: begin
            if (!second_ff && last_ff) begin
               second_in  = 1'b1;
               k_in       = idx_ff;
               s0_in      = s1_ff;
               s1_in      = s2_ff;
               s2_in      = '0;
               emitted_in = '0;
               state_in   = ST_CHECK;
            end else begin
               if (last_ff) begin
                  older_in   = '0;
                  middle_in  = '0;
                  samples_in = '0;
                  outputs_in = '0;
               end else begin
                  older_in   = middle_ff;
                  middle_in  = cur_ff;
                  samples_in = samples_ff + 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         src_len_ff   <= SRC_W'(1);
         dst_len_ff   <= DST_W'(1);
         older_ff     <= '0;
         middle_ff    <= '0;
         samples_ff   <= '0;
         outputs_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         src_len_ff   <= src_len_in;
         dst_len_ff   <= dst_len_in;
         older_ff     <= older_in;
         middle_ff    <= middle_in;
         samples_ff   <= samples_in;
         outputs_ff   <= outputs_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff      <= cur_in;
      idx_ff      <= idx_in;
      last_ff     <= last_in;
      second_ff   <= second_in;
      k_ff        <= k_in;
      s0_ff       <= s0_in;
      s1_ff       <= s1_in;
      s2_ff       <= s2_in;
      emitted_ff  <= emitted_in;
      f_ff        <= f_in;
      acc_ff      <= acc_in;
      rsp_pcm_ff  <= rsp_pcm_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pcm_out       = rsp_pcm_ff;
   assign rsp_last_of_sound = rsp_last_ff;

   // no new transfer while the divider is still working
   assert property (@(posedge clock) disable iff (reset) req_ready |-> !div_rsp.busy)
      else $error("input taken while divider busy");

   // a group never emits past its output budget
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (emitted_ff < EMIT_W'(MAX_RATIO)))
      else $error("output budget exceeded");

   // position quotient must fit the sample index
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POS_DIV && !div_rsp.busy) |-> (div_rsp.quot[DIV_W-1:SRC_W] == '0))
      else $error("position quotient overflow");

endmodule

// ===== rtl/core/qir_div_unit.sv =====
// Shared radix-2 restoring divider, one quotient bit per cycle.
module qir_div_unit (
   input  logic                clock,
   input  logic                reset,
   input  qir_pkg::div_req_type req,
   output qir_pkg::div_rsp_type rsp
);
   import qir_pkg::*;

   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [DST_W-1:0]  rem_ff, rem_in;
   logic [DST_W-1:0]  dvs_ff, dvs_in;
   logic [DIV_W-1:0]  sh_ff, sh_in;
   logic [DIV_W-1:0]  quot_ff, quot_in;
   logic [DST_W:0]    trial;
   logic [DST_W:0]    diff;
   logic              fits;

   always_comb begin
      trial   = {rem_ff, sh_ff[DIV_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      fits    = trial >= {1'b0, dvs_ff};
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      sh_in   = sh_ff;
      quot_in = quot_ff;
      if (req.start) begin
         cnt_in  = req.steps;
         rem_in  = req.init_rem;
         dvs_in  = req.divisor;
         sh_in   = req.bits;
         quot_in = '0;
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - 1'b1;
         sh_in   = {sh_ff[DIV_W-2:0], 1'b0};
         quot_in = {quot_ff[DIV_W-2:0], fits};
         rem_in  = fits ? diff[DST_W-1:0] : trial[DST_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      sh_ff   <= sh_in;
      quot_ff <= quot_in;
   end

   assign rsp.busy = (cnt_ff != '0);
   assign rsp.quot = quot_ff;
   assign rsp.rem  = rem_ff;

endmodule

// ===== rtl/core/qir_mul_unit.sv =====
// Shared signed multiplier with registered product.
module qir_mul_unit (
   input  logic                                clock,
   input  qir_pkg::mul_req_type                req,
   output logic signed [qir_pkg::MUL_P_W-1:0]  prod
);
   import qir_pkg::*;

   logic signed [MUL_A_W-1:0] op_a;
   logic signed [MUL_B_W-1:0] op_b;
   logic signed [MUL_P_W-1:0] prod_ff;

   assign op_a = $signed(req.a);
   assign op_b = $signed(req.b);

   always_ff @(posedge clock) begin
      if (req.en) begin
         prod_ff <= op_a * op_b;
      end
   end

   assign prod = prod_ff;

endmodule
